// ----- rtl/uhse_pkg.sv -----
// uhse_pkg: item types, register indexes and fixed-point helpers for the
// uniform Hermite spline set evaluator. Depends on nothing.
package uhse_pkg;

    // Fixed-point format and internal widths
    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;   // t in 0..ONE
    localparam int ACC_W     = 56;              // coefficients and chain values
    localparam int WIDE_W    = 94;              // split product recombination
    localparam int RES_W     = 74;              // scaled derivative before clamp
    localparam int HALF_W    = 28;              // operand split point

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SPLINE_COUNT = 2'd0;
    localparam logic [1:0] CFG_NODE_COUNT   = 2'd1;
    localparam logic [1:0] CFG_GRID_STEP    = 2'd2;
    localparam logic [1:0] CFG_INV_STEP     = 2'd3;

    typedef struct packed {
        logic               kind;
        logic [5:0]         spline_index;
        logic [9:0]         node_index;
        logic signed [31:0] node_value;
        logic signed [31:0] node_slope;
        logic [31:0]        radius;
    } t_in;

    typedef struct packed {
        logic [5:0]         out_spline;
        logic signed [31:0] spline_value;
        logic signed [31:0] spline_slope;
        logic               last;
        logic               out_of_range;
    } t_out;

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [RES_W-1:0] v);
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        hi = RES_W'(64'sd2147483647);
        lo = -RES_W'(64'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ----- rtl/uniform_hermite_spline_set_eval_top.sv -----
// uniform_hermite_spline_set_eval_top: spline node stores, divider and
// sequencer around one shared 33x33 multiplier. Depends on uhse_pkg.
//
// A load item writes one node value and slope and busy stays low. An evaluate
// item keeps busy high while a one-bit-per-cycle divider finds the interval,
// one multiply gives t, then every spline takes two store reads, two
// multiplies for its end slopes, one coefficient step and six split multiplies
// (each a high-half and a low-half step) on the shared multiplier. Results
// leave on o_out with o_strobe high for one cycle each, in spline order, and
// cannot be held off.
// The configuration port is always ready; write it only while busy is low.
module uniform_hermite_spline_set_eval_top #(
    parameter int MAX_SPLINES = 64,
    parameter int MAX_NODES   = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  uhse_pkg::t_in   i_in,
    output logic            o_strobe,
    output uhse_pkg::t_out  o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);
    import uhse_pkg::*;

    localparam int DEPTH  = MAX_SPLINES * MAX_NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SPL_W  = (MAX_SPLINES > 1) ? $clog2(MAX_SPLINES) : 1;
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam logic [31:0] MS  = 32'(MAX_SPLINES);
    localparam logic [31:0] MN  = 32'(MAX_NODES);
    localparam logic [T_W-1:0] ONE_T = T_W'(1) << FRAC_BITS;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DIV  = 11'b000_0000_0010,
        S_POS  = 11'b000_0000_0100,
        S_TM   = 11'b000_0000_1000,
        S_RD0  = 11'b000_0001_0000,
        S_RD1  = 11'b000_0010_0000,
        S_C1   = 11'b000_0100_0000,
        S_E1   = 11'b000_1000_0000,
        S_CF   = 11'b001_0000_0000,
        S_MH   = 11'b010_0000_0000,
        S_ML   = 11'b100_0000_0000
    } t_state;

    // Configuration registers
    logic [6:0]  r_cfg_sc;
    logic [10:0] r_cfg_nc;
    logic [31:0] r_cfg_gs;
    logic [31:0] r_cfg_inv;

    // Sequencer state
    t_state             r_state;
    logic [4:0]         r_cnt;
    logic [31:0]        r_rem, r_quo, r_h, r_x;
    logic [NODE_W-1:0]  r_nn_m2, r_iv;
    logic               r_oor;
    logic [T_W-1:0]     r_t;
    logic [SPL_W-1:0]   r_k, r_klast;
    logic [ADDR_W-1:0]  r_base;
    logic signed [31:0] r_y0, r_y1, r_d0, r_d1, r_val;
    logic signed [ACC_W-1:0] r_c1, r_e1, r_c2, r_c3, r_a;
    logic signed [65:0] r_p;
    logic [2:0]         r_op;
    logic               r_strobe;
    t_out               r_out;

    // Node stores
    logic signed [31:0] r_value_mem [DEPTH];
    logic signed [31:0] r_slope_mem [DEPTH];
    logic signed [31:0] r_qv, r_qs;

    logic               acc_in, eval_go, load_go, cfg_we;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [31:0]        sp32, np32, ns32, nsc, nn32, nnc, gs_eff;
    logic [32:0]        sh, hx;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod, pt;
    logic signed [WIDE_W-1:0] full, res;
    logic signed [ACC_W-1:0]  res56, c1x, e1x, y0x, y1x, c2_n, c3_n;
    logic signed [32:0] b_op;

    assign acc_in  = start && !busy;
    assign eval_go = acc_in && (i_in.kind == KIND_EVAL);
    assign sp32    = 32'(i_in.spline_index);
    assign np32    = 32'(i_in.node_index);
    assign load_go = acc_in && (i_in.kind == KIND_LOAD) && (sp32 < MS) && (np32 < MN);
    assign waddr   = ADDR_W'(sp32 * MN + np32);
    assign raddr   = (r_state == S_RD1) ? r_base + ADDR_W'(1) : r_base;
    assign cfg_we  = i_cfg_valid && o_cfg_ready;

    // Clamp register values into their working ranges
    assign ns32   = 32'(r_cfg_sc);
    assign nsc    = (ns32 == 32'd0) ? 32'd1 : ((ns32 > MS) ? MS : ns32);
    assign nn32   = 32'(r_cfg_nc);
    assign nnc    = (nn32 < 32'd2) ? 32'd2 : ((nn32 > MN) ? MN : nn32);
    assign gs_eff = (r_cfg_gs == 32'd0) ? 32'd1 : r_cfg_gs;

    // Divider step
    assign sh = {r_rem, r_quo[31]};
    assign hx = {1'b0, r_h};

    // Coefficients
    assign y0x  = ACC_W'(r_y0);
    assign y1x  = ACC_W'(r_y1);
    assign c1x  = r_c1;
    assign e1x  = r_e1;
    assign c2_n = -(ACC_W'(3) * y0x) - (c1x <<< 1) + ACC_W'(3) * y1x - e1x;
    assign c3_n = (y0x <<< 1) + c1x - (y1x <<< 1) + e1x;

    // Shared multiplier operand select
    assign b_op = (r_op == 3'd5) ? $signed({1'b0, r_cfg_inv}) : $signed(33'(r_t));
    always_comb begin
        unique case (r_state)
            S_TM: begin
                mul_a = $signed({1'b0, r_x});
                mul_b = $signed({1'b0, r_cfg_inv});
            end
            S_C1: begin
                mul_a = $signed({1'b0, r_h});
                mul_b = 33'(r_d0);
            end
            S_E1: begin
                mul_a = $signed({1'b0, r_h});
                mul_b = 33'(r_d1);
            end
            S_MH: begin
                mul_a = 33'($signed(r_a[ACC_W-1:HALF_W]));
                mul_b = b_op;
            end
            S_ML: begin
                mul_a = $signed({5'b0, r_a[HALF_W-1:0]});
                mul_b = b_op;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign prod  = mul_a * mul_b;
    assign pt    = prod >>> FRAC_BITS;
    assign full  = (WIDE_W'(r_p) <<< HALF_W) + WIDE_W'(prod);
    assign res   = full >>> FRAC_BITS;
    assign res56 = res[ACC_W-1:0];

    // Store write on load, registered read for the sequencer
    always_ff @(posedge i_clk) begin
        if (load_go) begin
            r_value_mem[waddr] <= i_in.node_value;
        end
        r_qv <= r_value_mem[raddr];
    end
    always_ff @(posedge i_clk) begin
        if (load_go) begin
            r_slope_mem[waddr] <= i_in.node_slope;
        end
        r_qs <= r_slope_mem[raddr];
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sc  <= 7'd1;
            r_cfg_nc  <= 11'd2;
            r_cfg_gs  <= 32'd1 << FRAC_BITS;
            r_cfg_inv <= 32'd1 << FRAC_BITS;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPLINE_COUNT: r_cfg_sc  <= i_cfg_data[6:0];
                CFG_NODE_COUNT:   r_cfg_nc  <= i_cfg_data[10:0];
                CFG_GRID_STEP:    r_cfg_gs  <= i_cfg_data;
                CFG_INV_STEP:     r_cfg_inv <= i_cfg_data;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: if (eval_go) r_state <= S_DIV;
                S_DIV:  if (r_cnt == 5'd0) r_state <= S_POS;
                S_POS:  r_state <= S_TM;
                S_TM:   r_state <= S_RD0;
                S_RD0:  r_state <= S_RD1;
                S_RD1:  r_state <= S_C1;
                S_C1:   r_state <= S_E1;
                S_E1:   r_state <= S_CF;
                S_CF:   r_state <= S_MH;
                S_MH:   r_state <= S_ML;
                S_ML: begin
                    if (r_op != 3'd5) begin
                        r_state <= S_MH;
                    end else begin
                        r_strobe <= 1'b1;
                        r_state  <= (r_k == r_klast) ? S_IDLE : S_RD0;
                    end
                end
            endcase
        end
    end

    // Datapath: divide, clamp, read nodes, walk the multiply chain
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_quo   <= i_in.radius;
                r_rem   <= '0;
                r_cnt   <= 5'd31;
                r_h     <= gs_eff;
                r_klast <= SPL_W'(nsc - 32'd1);
                r_nn_m2 <= NODE_W'(nnc - 32'd2);
            end
            S_DIV: begin
                r_cnt <= r_cnt - 5'd1;
                if (sh >= hx) begin
                    r_rem <= 32'(sh - hx);
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= sh[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
            end
            S_POS: begin
                if (r_quo > 32'(r_nn_m2)) begin
                    r_iv  <= r_nn_m2;
                    r_x   <= r_h;
                    r_oor <= !((r_quo == 32'(r_nn_m2) + 32'd1) && (r_rem == 32'd0));
                end else begin
                    r_iv  <= r_quo[NODE_W-1:0];
                    r_x   <= r_rem;
                    r_oor <= 1'b0;
                end
            end
            S_TM: begin
                r_t    <= (pt > 66'(ONE_T)) ? ONE_T : pt[T_W-1:0];
                r_base <= ADDR_W'(r_iv);
                r_k    <= '0;
            end
            S_RD0: begin
                r_op <= 3'd0;
            end
            S_RD1: begin
                r_y0 <= r_qv;
                r_d0 <= r_qs;
            end
            S_C1: begin
                r_y1 <= r_qv;
                r_d1 <= r_qs;
                r_c1 <= pt[ACC_W-1:0];
            end
            S_E1: begin
                r_e1 <= pt[ACC_W-1:0];
            end
            S_CF: begin
                r_c2 <= c2_n;
                r_c3 <= c3_n;
                r_a  <= c3_n;
            end
            S_MH: begin
                r_p <= prod;
            end
            S_ML: begin
                r_op <= r_op + 3'd1;
                unique case (r_op)
                    3'd0: r_a <= r_c2 + res56;
                    3'd1: r_a <= r_c1 + res56;
                    3'd2: begin
                        r_val <= sat32(RES_W'(y0x + res56));
                        r_a   <= ACC_W'(3) * r_c3;
                    end
                    3'd3: r_a <= (r_c2 <<< 1) + res56;
                    3'd4: r_a <= r_c1 + res56;
                    3'd5: begin
                        r_out.out_spline   <= 6'(r_k);
                        r_out.spline_value <= r_val;
                        r_out.spline_slope <= sat32(res[RES_W-1:0]);
                        r_out.last         <= (r_k == r_klast);
                        r_out.out_of_range <= r_oor;
                        r_k    <= r_k + SPL_W'(1);
                        r_base <= r_base + ADDR_W'(MAX_NODES);
                    end
                    default: r_a <= r_a;
                endcase
            end
        endcase
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // Sequencer is always in exactly one state
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");

    // An accepted evaluation keeps the block busy
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eval_go |=> busy) else $error("evaluation not started");

    // A load never makes the block busy
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && i_in.kind == KIND_LOAD) |=> !busy) else $error("load raised busy");

    // Results are spaced apart
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("back-to-back results");

    // The last result of an evaluation ends the busy period
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_out.last) |-> !busy) else $error("busy after last result");

endmodule

// ----- tb/sv/uhse_checker.sv -----
// uhse_checker: watches the item, result and register channels of the spline
// set evaluator, predicts each evaluation and compares results. Depends on uhse_pkg.
`timescale 1ns / 100ps

module uhse_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_busy,
    input  uhse_pkg::t_in  i_in,
    input  logic           i_strobe,
    input  uhse_pkg::t_out i_out,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    output int             o_fail_count,
    output int             o_pending
);
    import uhse_pkg::*;

    localparam int        NODES = 1024;
    localparam longint    ONE   = 64'd65536;

    typedef logic signed [127:0] wide_t;

    // Shadow copies of the node stores and registers
    logic signed [31:0] node_vals   [int];
    logic signed [31:0] node_slopes [int];
    logic [6:0]         spl_cnt;
    logic [10:0]        nod_cnt;
    logic [31:0]        step_q;
    logic [31:0]        inv_q;

    t_out expected_results[$];
    int   fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic wide_t frac_mul(wide_t a, wide_t t);
        return (a * t) >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(wide_t v);
        wide_t hi;
        wide_t lo;
        hi = 128'sd2147483647;
        lo = -128'sd2147483648;
        if (v > hi) return 32'sh7FFF_FFFF;
        if (v < lo) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Queue the results of one evaluation at radius r
    function automatic void predict_spline_set(logic [31:0] r);
        longint unsigned ns, nn, h, iv, x;
        logic [127:0]    tprod;
        wide_t           t, hw, iw, y0, y1, d0, d1, c1, e1, c2, c3, val, dydt;
        logic            oor;
        t_out            res;
        ns  = (spl_cnt < 1) ? 1 : ((spl_cnt > 64) ? 64 : spl_cnt);
        nn  = (nod_cnt < 2) ? 2 : ((nod_cnt > NODES) ? NODES : nod_cnt);
        h   = (step_q == 0) ? 1 : step_q;
        oor = 1'b0;
        iv  = r / h;
        if (iv > nn - 2) iv = nn - 2;
        x = r - iv * h;
        if (x > h) begin
            x   = h;
            oor = 1'b1;
        end
        tprod = (128'(x) * 128'(inv_q)) >> 16;
        t     = (tprod > 128'(ONE)) ? wide_t'(ONE) : wide_t'(tprod);
        hw    = {96'b0, 32'(h)};
        iw    = {96'b0, inv_q};
        for (int k = 0; k < int'(ns); k++) begin
            y0   = node_vals[k * NODES + int'(iv)];
            y1   = node_vals[k * NODES + int'(iv) + 1];
            d0   = node_slopes[k * NODES + int'(iv)];
            d1   = node_slopes[k * NODES + int'(iv) + 1];
            c1   = (hw * d0) >>> 16;
            e1   = (hw * d1) >>> 16;
            c2   = -3 * y0 - 2 * c1 + 3 * y1 - e1;
            c3   = 2 * y0 + c1 - 2 * y1 + e1;
            val  = y0 + frac_mul(c1 + frac_mul(c2 + frac_mul(c3, t), t), t);
            dydt = c1 + frac_mul(2 * c2 + frac_mul(3 * c3, t), t);
            res.out_spline   = 6'(k);
            res.spline_value = clamp32(val);
            res.spline_slope = clamp32((dydt * iw) >>> 16);
            res.last         = (k == int'(ns) - 1);
            res.out_of_range = oor;
            expected_results.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            spl_cnt    <= 7'd1;
            nod_cnt    <= 11'd2;
            step_q     <= 32'h0001_0000;
            inv_q      <= 32'h0001_0000;
            fail_count <= 0;
        end else begin
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPLINE_COUNT: spl_cnt <= i_cfg_data[6:0];
                    CFG_NODE_COUNT:   nod_cnt <= i_cfg_data[10:0];
                    CFG_GRID_STEP:    step_q  <= i_cfg_data;
                    CFG_INV_STEP:     inv_q   <= i_cfg_data;
                    default: ;
                endcase
            end
            // Store loads, predict evaluations
            if (i_start && !i_busy) begin
                if (i_in.kind == KIND_LOAD) begin
                    node_vals[i_in.spline_index * NODES + i_in.node_index]   = i_in.node_value;
                    node_slopes[i_in.spline_index * NODES + i_in.node_index] = i_in.node_slope;
                end else begin
                    predict_spline_set(i_in.radius);
                end
            end
            // Compare each result with the oldest expectation
            if (i_strobe) begin
                if (expected_results.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("mismatch: unexpected result %p", i_out);
                end else begin
                    want = expected_results.pop_front();
                    if (want.out_spline !== i_out.out_spline
                        || want.spline_value !== i_out.spline_value
                        || want.spline_slope !== i_out.spline_slope
                        || want.last !== i_out.last
                        || want.out_of_range !== i_out.out_of_range) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %p got %p", want, i_out);
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/uniform_hermite_spline_set_eval_top_tb.sv -----
// uniform_hermite_spline_set_eval_top_tb: drives loads, evaluations and register
// writes into the spline set evaluator. Depends on uhse_pkg and uhse_checker.
`timescale 1ns / 100ps

module uniform_hermite_spline_set_eval_top_tb;
    import uhse_pkg::*;

    localparam int     NODES      = 1024;
    localparam int     STALL_MAX  = 5000;
    localparam int     ITEM_GOAL  = 470;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_in;
    logic        o_strobe;
    t_out        o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          fail_count;
    int          pending;

    bit          node_loaded [0:65535];
    int          items_sent;
    int          stall_cycles;
    logic [6:0]  cur_splines;
    logic [10:0] cur_nodes;
    logic [31:0] cur_step;

    uniform_hermite_spline_set_eval_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .o_strobe(o_strobe), .o_out(o_out), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    uhse_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_in(i_in),
        .i_strobe(o_strobe), .i_out(o_out), .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX) begin
                $display("FAIL uniform_hermite_spline_set_eval_top");
                $finish;
            end
        end
    end

    function automatic int eff_splines();
        return (cur_splines < 1) ? 1 : ((cur_splines > 64) ? 64 : int'(cur_splines));
    endfunction

    // Interval that an evaluation at r reads
    function automatic int read_interval(logic [31:0] r);
        longint unsigned nn, h, iv;
        nn = (cur_nodes < 2) ? 2 : ((cur_nodes > NODES) ? NODES : cur_nodes);
        h  = (cur_step == 0) ? 1 : cur_step;
        iv = r / h;
        if (iv > nn - 2) iv = nn - 2;
        return int'(iv);
    endfunction

    // Hold one item until accepted, then idle at random
    task automatic send_item(t_in it);
        int gap_pct;
        i_in  <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        items_sent++;
        gap_pct = (items_sent < ITEM_GOAL / 3) ? 8 : ((items_sent < 2 * ITEM_GOAL / 3) ? 66 : 0);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic load_node(int s, int n, logic [31:0] v, logic [31:0] d);
        t_in it;
        it              = '0;
        it.kind         = KIND_LOAD;
        it.spline_index = 6'(s);
        it.node_index   = 10'(n);
        it.node_value   = v;
        it.node_slope   = d;
        it.radius       = $urandom();
        node_loaded[s * NODES + n] = 1'b1;
        send_item(it);
    endtask

    // Fill any node the evaluation would read, then evaluate
    task automatic eval_at(logic [31:0] r);
        t_in it;
        int  iv;
        iv = read_interval(r);
        for (int k = 0; k < eff_splines(); k++)
            for (int n = iv; n <= iv + 1; n++)
                if (!node_loaded[k * NODES + n])
                    load_node(k, n, $urandom(), $urandom());
        it              = '0;
        it.kind         = KIND_EVAL;
        it.spline_index = $urandom();
        it.node_index   = $urandom();
        it.node_value   = $urandom();
        it.node_slope   = $urandom();
        it.radius       = r;
        send_item(it);
    endtask

    // Drain results and let the block settle
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Hold one register write until accepted; valid stays up for the next one
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_regs(logic [31:0] sc, logic [31:0] nc, logic [31:0] gs, logic [31:0] inv);
        wait_idle();
        write_reg(CFG_SPLINE_COUNT, sc);
        write_reg(CFG_NODE_COUNT, nc);
        write_reg(CFG_GRID_STEP, gs);
        write_reg(CFG_INV_STEP, inv);
        // Drop valid once the last register is written
        i_cfg_valid <= 1'b0;
        cur_splines = sc[6:0];
        cur_nodes   = nc[10:0];
        cur_step    = gs;
    endtask

    // Mix of evaluations, mostly inside the grid, and stray loads
    task automatic random_items(int count);
        longint unsigned span, h, nn;
        logic [31:0]     r;
        h    = (cur_step == 0) ? 1 : cur_step;
        nn   = (cur_nodes < 2) ? 2 : ((cur_nodes > NODES) ? NODES : cur_nodes);
        span = (nn - 1) * h;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 15) begin
                load_node($urandom_range(63), $urandom_range(1023), $urandom(), $urandom());
            end else begin
                if ($urandom_range(99) < 75)
                    r = 32'((({$urandom(), $urandom()}) % (span + 1)));
                else
                    r = $urandom();
                eval_at(r);
            end
        end
    endtask

    initial begin
        logic [31:0] gs;
        items_sent  = 0;
        cur_splines = 7'd1;
        cur_nodes   = 11'd2;
        cur_step    = 32'h0001_0000;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SPLINE_COUNT;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: extreme node values, grid ends, beyond the grid
        load_node(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        load_node(0, 1, 32'h8000_0000, 32'h7FFF_FFFF);
        eval_at(32'h0000_0000);
        eval_at(32'h0000_8000);
        eval_at(32'h0001_0000);
        eval_at(32'h0001_0001);
        eval_at(32'hFFFF_FFFF);
        load_node(63, 1023, 32'hFFFF_FFFF, 32'h0000_0000);
        load_node(0, 1, 32'h0000_0000, 32'hFFFF_FFFF);
        eval_at(32'h0000_C000);

        // Most splines, fewest nodes; saturated counts and zero step
        set_regs(32'd64, 32'd2, 32'h0001_0000, 32'h0001_0000);
        eval_at(32'h0000_4000);
        eval_at(32'h0002_0000);
        set_regs(32'd0, 32'd0, 32'd0, 32'd1);
        eval_at(32'd0);
        eval_at(32'd1);
        eval_at(32'd2);
        // Most nodes, smallest step, largest inverse
        set_regs(32'd1, 32'd1024, 32'd1, 32'hFFFF_FFFF);
        eval_at(32'd1022);
        eval_at(32'd1023);
        eval_at(32'd1024);
        eval_at(32'd517);
        // Counts above range, largest step, smallest inverse
        set_regs(32'hFFFF_FFFF, 32'h7FF, 32'hFFFF_FFFF, 32'd1);
        eval_at(32'hFFFF_FFFE);
        eval_at(32'd12345);

        // Random settings, mostly matched step and inverse
        while (items_sent < ITEM_GOAL) begin
            gs = $urandom_range(32'h0000_4000, 32'h0004_0000);
            set_regs($urandom_range(1, 8), $urandom_range(2, 16), gs,
                     ($urandom_range(99) < 80) ? 32'((64'd1 << 32) / gs) : $urandom());
            random_items($urandom_range(10, 40));
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS uniform_hermite_spline_set_eval_top");
        else
            $display("FAIL uniform_hermite_spline_set_eval_top");
        $finish;
    end

endmodule
